@@ hdl/venetian_blinds_pixel_mask_top_defines.svh @@
// ----------------------------------------------------------------------------
// venetian blinds pixel mask assertion macros
// shared property templates for the checker, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef VENETIAN_BLINDS_PIXEL_MASK_TOP_DEFINES_SVH
`define VENETIAN_BLINDS_PIXEL_MASK_TOP_DEFINES_SVH

// same-cycle implication
`define VBPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VBPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// vbpm_pkg
// types, widths and reset values shared by the venetian blinds pixel mask
// ----------------------------------------------------------------------------
package vbpm_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int PIX_W          = 12;
    localparam int CH_W           = 8;
    localparam int RGBA_W         = 4 * CH_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int OFS_W          = 14;   // doubled centre offset
    localparam int MUL_W          = 30;   // offset times direction
    localparam int SUM_W          = 32;   // projection sum
    localparam int PROJ_W         = 30;   // clamped projection
    localparam int PHASE_W        = 16;
    localparam int DIFF_W         = 23;
    localparam int GPROD_W        = 39;
    localparam int FACTOR_W       = 17;

    localparam logic [FACTOR_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FACTOR_W-1:0] PASS_LIMIT = 17'd65470;

    localparam logic signed [15:0] DIR_X_RST        = 16'sd16384;
    localparam logic signed [15:0] DIR_Y_RST        = 16'sd0;
    localparam logic [12:0]        IMAGE_WIDTH_RST  = 13'd1920;
    localparam logic [12:0]        IMAGE_HEIGHT_RST = 13'd1080;
    localparam logic [27:0]        MAX_PROJ_RST     = 28'd31457280;
    localparam logic [31:0]        BLIND_SCALE_RST  = 32'd0;
    localparam logic signed [21:0] THRESHOLD_RST    = 22'sd0;
    localparam logic [14:0]        EDGE_GAIN_RST    = 15'd4265;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_X          = 3'd0,
        CFG_DIR_Y          = 3'd1,
        CFG_IMAGE_WIDTH    = 3'd2,
        CFG_IMAGE_HEIGHT   = 3'd3,
        CFG_MAX_PROJECTION = 3'd4,
        CFG_BLIND_SCALE    = 3'd5,
        CFG_OPEN_THRESHOLD = 3'd6,
        CFG_EDGE_GAIN      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [27:0]        max_projection;
        logic [31:0]        blind_scale;
        logic signed [21:0] open_threshold;
        logic [14:0]        edge_gain;
    } cfg_t;

endpackage

@@ hdl/vbpm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// vbpm_cfg_regs
// per-frame configuration registers with write decode and reset defaults
// ----------------------------------------------------------------------------
module vbpm_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [vbpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vbpm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output vbpm_pkg::cfg_t                       cfg
);

    vbpm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dir_x          <= vbpm_pkg::DIR_X_RST;
            cfg_reg.dir_y          <= vbpm_pkg::DIR_Y_RST;
            cfg_reg.image_width    <= vbpm_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height   <= vbpm_pkg::IMAGE_HEIGHT_RST;
            cfg_reg.max_projection <= vbpm_pkg::MAX_PROJ_RST;
            cfg_reg.blind_scale    <= vbpm_pkg::BLIND_SCALE_RST;
            cfg_reg.open_threshold <= vbpm_pkg::THRESHOLD_RST;
            cfg_reg.edge_gain      <= vbpm_pkg::EDGE_GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (vbpm_pkg::cfg_idx_t'(cfg_index))
                vbpm_pkg::CFG_DIR_X:          cfg_reg.dir_x          <= cfg_data[15:0];
                vbpm_pkg::CFG_DIR_Y:          cfg_reg.dir_y          <= cfg_data[15:0];
                vbpm_pkg::CFG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[12:0];
                vbpm_pkg::CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[12:0];
                vbpm_pkg::CFG_MAX_PROJECTION: cfg_reg.max_projection <= cfg_data[27:0];
                vbpm_pkg::CFG_BLIND_SCALE:    cfg_reg.blind_scale    <= cfg_data[31:0];
                vbpm_pkg::CFG_OPEN_THRESHOLD: cfg_reg.open_threshold <= cfg_data[21:0];
                vbpm_pkg::CFG_EDGE_GAIN:      cfg_reg.edge_gain      <= cfg_data[14:0];
                default:                      cfg_reg.edge_gain      <= cfg_reg.edge_gain;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/venetian_blinds_pixel_mask_top.sv @@
// ----------------------------------------------------------------------------
// venetian_blinds_pixel_mask_top
// venetian blinds transition mask: one rgba pixel in, one masked pixel out
// ----------------------------------------------------------------------------
//  channel   valid       stall       payload
//  input     in_valid    in_stall    pixel_x, pixel_y, red_in .. alpha_in
//  output    out_valid   out_stall   red_out .. alpha_out, passed_through
//  config    cfg_write   -           cfg_index, cfg_data
//
//  one pixel per cycle sustained while out_stall is low
//  the datapath is a seven-stage register pipeline: offset, direction
//  multiply, projection sum, blind scale multiply, gain multiply, factor
//  clamp, channel multiply
//  reset clears the stage valid bits and loads the config defaults
//  out_stall holds the output stage; empty stages upstream keep filling, and
//  in_stall rises only when all seven stages hold a pixel
// ----------------------------------------------------------------------------
module venetian_blinds_pixel_mask_top
#(
    parameter int COORD_BITS = vbpm_pkg::COORD_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vbpm_pkg::PIX_W-1:0]           pixel_x,
    input  logic [vbpm_pkg::PIX_W-1:0]           pixel_y,
    input  logic [vbpm_pkg::CH_W-1:0]            red_in,
    input  logic [vbpm_pkg::CH_W-1:0]            green_in,
    input  logic [vbpm_pkg::CH_W-1:0]            blue_in,
    input  logic [vbpm_pkg::CH_W-1:0]            alpha_in,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vbpm_pkg::CH_W-1:0]            red_out,
    output logic [vbpm_pkg::CH_W-1:0]            green_out,
    output logic [vbpm_pkg::CH_W-1:0]            blue_out,
    output logic [vbpm_pkg::CH_W-1:0]            alpha_out,
    output logic                                 passed_through,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [vbpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vbpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // coordinate bits actually used; never more than the PIX_W port width
    localparam int CW = (COORD_BITS < vbpm_pkg::PIX_W) ? COORD_BITS : vbpm_pkg::PIX_W;
    localparam int NSTG = 7;

    vbpm_pkg::cfg_t cfg;

    vbpm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------------
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] rdy;

    always_comb
    begin
        rdy[NSTG] = !vld_reg[NSTG] || !out_stall;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_stall  = !rdy[1];
    assign out_valid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel channels and empty-frame flag ride along with the math
    // ------------------------------------------------------------------------
    logic [vbpm_pkg::RGBA_W-1:0] rgba_reg  [1:NSTG-1];
    logic                        empty_reg [1:5];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            rgba_reg[1]  <= {red_in, green_in, blue_in, alpha_in};
            empty_reg[1] <= (cfg.image_width == '0) || (cfg.image_height == '0);
        end
        for (int k = 2; k <= NSTG - 1; k++)
        begin
            if (rdy[k])
            begin
                rgba_reg[k] <= rgba_reg[k-1];
            end
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (rdy[k])
            begin
                empty_reg[k] <= empty_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: doubled offset from the frame centre, in half pixels
    // ------------------------------------------------------------------------
    logic [CW-1:0]                     px_c;
    logic [CW-1:0]                     py_c;
    logic signed [vbpm_pkg::OFS_W-1:0] dx2_next, dx2_reg;
    logic signed [vbpm_pkg::OFS_W-1:0] dy2_next, dy2_reg;

    assign px_c = pixel_x[CW-1:0];
    assign py_c = pixel_y[CW-1:0];

    always_comb
    begin
        dx2_next = $signed(vbpm_pkg::OFS_W'({px_c, 1'b0}))
                 - $signed(vbpm_pkg::OFS_W'(cfg.image_width));
        dy2_next = $signed(vbpm_pkg::OFS_W'({py_c, 1'b0}))
                 - $signed(vbpm_pkg::OFS_W'(cfg.image_height));
    end

    // ------------------------------------------------------------------------
    // stage 2: offset times direction vector
    // ------------------------------------------------------------------------
    logic signed [vbpm_pkg::MUL_W-1:0] mx_next, mx_reg;
    logic signed [vbpm_pkg::MUL_W-1:0] my_next, my_reg;

    always_comb
    begin
        mx_next = dx2_reg * cfg.dir_x;
        my_next = dy2_reg * cfg.dir_y;
    end

    // ------------------------------------------------------------------------
    // stage 3: projection plus max projection, negative saturates to zero
    // ------------------------------------------------------------------------
    logic signed [vbpm_pkg::SUM_W-1:0] proj_sum;
    logic [vbpm_pkg::PROJ_W-1:0]       proj_next, proj_reg;

    always_comb
    begin
        proj_sum  = vbpm_pkg::SUM_W'(mx_reg) + vbpm_pkg::SUM_W'(my_reg)
                  + $signed({4'b0, cfg.max_projection});
        proj_next = proj_sum[vbpm_pkg::SUM_W-1] ? '0 : proj_sum[vbpm_pkg::PROJ_W-1:0];
    end

    // ------------------------------------------------------------------------
    // stage 4: blind phase is the fraction of projection times blind scale
    // ------------------------------------------------------------------------
    logic [31:0]                   scaled;
    logic [vbpm_pkg::PHASE_W-1:0]  phase_next, phase_reg;

    always_comb
    begin
        scaled     = proj_reg * cfg.blind_scale;   // low 32 bits only
        phase_next = scaled[31:16];
    end

    // ------------------------------------------------------------------------
    // stage 5: (phase - threshold) * gain, Q.24
    // ------------------------------------------------------------------------
    logic signed [vbpm_pkg::DIFF_W-1:0]  diff;
    logic signed [vbpm_pkg::GPROD_W-1:0] gprod_next, gprod_reg;

    always_comb
    begin
        diff       = $signed({7'b0, phase_reg}) - vbpm_pkg::DIFF_W'(cfg.open_threshold);
        gprod_next = diff * $signed({1'b0, cfg.edge_gain});
    end

    // ------------------------------------------------------------------------
    // stage 6: clamp to [0, 1] in Q1.16 and decide pass-through
    // ------------------------------------------------------------------------
    logic [vbpm_pkg::FACTOR_W-1:0] factor_next, factor_reg;
    logic                          pass_next, pass_reg;

    always_comb
    begin
        if (gprod_reg <= 0)
        begin
            factor_next = '0;
        end
        else if (gprod_reg[vbpm_pkg::GPROD_W-1:8] > 31'(vbpm_pkg::ONE_Q16))
        begin
            factor_next = vbpm_pkg::ONE_Q16;
        end
        else
        begin
            factor_next = gprod_reg[vbpm_pkg::FACTOR_W+7:8];
        end
        pass_next = empty_reg[5] || (factor_next > vbpm_pkg::PASS_LIMIT);
    end

    // ------------------------------------------------------------------------
    // stage 7: pass each channel unchanged or scale it by the factor, truncating
    // ------------------------------------------------------------------------
    logic [vbpm_pkg::CH_W+vbpm_pkg::FACTOR_W-1:0] ch_prod [4];
    logic [vbpm_pkg::RGBA_W-1:0]                  rgba_out_next, rgba_out_reg;
    logic                                         pass_out_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ch_prod[i] = rgba_reg[6][i*vbpm_pkg::CH_W +: vbpm_pkg::CH_W] * factor_reg;
            rgba_out_next[i*vbpm_pkg::CH_W +: vbpm_pkg::CH_W] =
                pass_reg ? rgba_reg[6][i*vbpm_pkg::CH_W +: vbpm_pkg::CH_W]
                         : ch_prod[i][23:16];
        end
    end

    // ------------------------------------------------------------------------
    // datapath registers, loaded when their stage moves
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            dx2_reg <= dx2_next;
            dy2_reg <= dy2_next;
        end
        if (rdy[2])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
        if (rdy[3])
        begin
            proj_reg <= proj_next;
        end
        if (rdy[4])
        begin
            phase_reg <= phase_next;
        end
        if (rdy[5])
        begin
            gprod_reg <= gprod_next;
        end
        if (rdy[6])
        begin
            factor_reg <= factor_next;
            pass_reg   <= pass_next;
        end
        if (rdy[7])
        begin
            rgba_out_reg <= rgba_out_next;
            pass_out_reg <= pass_reg;
        end
    end

    assign red_out        = rgba_out_reg[31:24];
    assign green_out      = rgba_out_reg[23:16];
    assign blue_out       = rgba_out_reg[15:8];
    assign alpha_out      = rgba_out_reg[7:0];
    assign passed_through = pass_out_reg;

endmodule

@@ hdl/vbpm_checker.sv @@
// ----------------------------------------------------------------------------
// vbpm_checker
// port-level assertions for the venetian blinds pixel mask, bound to the top
// ----------------------------------------------------------------------------
`include "venetian_blinds_pixel_mask_top_defines.svh"

module vbpm_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [vbpm_pkg::CH_W-1:0]     red_out,
    input  logic [vbpm_pkg::CH_W-1:0]     green_out,
    input  logic [vbpm_pkg::CH_W-1:0]     blue_out,
    input  logic [vbpm_pkg::CH_W-1:0]     alpha_out,
    input  logic                          passed_through
);

    // input backs up only behind a stalled result
    `VBPM_ASSERT_IMPL(a_stall_needs_blocked_out, in_stall, out_valid && out_stall, "in_stall without a stalled result")

    // a full pipe stays full, so the input stall then follows the output stall
    `VBPM_ASSERT_NEXT(a_full_pipe_holds, in_stall, in_stall == out_stall, "full pipe released input while output blocked")

    // stalled result holds
    `VBPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(alpha_out) && $stable(passed_through), "stalled result changed")

    // a result leaves only by transfer
    `VBPM_ASSERT_IMPL(a_out_leave, $fell(out_valid), !$past(out_stall), "result dropped without transfer")

endmodule

bind venetian_blinds_pixel_mask_top vbpm_checker u_vbpm_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out),
    .alpha_out      (alpha_out),
    .passed_through (passed_through)
);
